FILE: rtl/fir_highpass_37tap_unit_defines.svh
// Assertion macros for the FIR high-pass unit.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef FIR_HIGHPASS_37TAP_UNIT_DEFINES_SVH
`define FIR_HIGHPASS_37TAP_UNIT_DEFINES_SVH

// Same-cycle implication, skipped while reset is high.
`define FHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define FHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fhp_pkg.sv
// Package for the FIR high-pass unit: sizes, coefficient ROM, state type.
// Depends on nothing.
package fhp_pkg;

   localparam int TAPS           = 37;
   localparam int SAMPLE_BITS    = 12;
   localparam int COEF_FRAC_BITS = 19;
   localparam int COEF_BITS      = 20;
   localparam int ROM_DEPTH      = 37;
   localparam int ACC_BITS       = 38;
   localparam int OUT_BITS       = 14;

   localparam int DLY_DEPTH    = TAPS - 1;
   localparam int PTR_BITS     = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
   localparam int TAP_BITS     = $clog2(TAPS);
   localparam int ROM_IDX_BITS = $clog2(ROM_DEPTH);
   localparam int PROD_BITS    = SAMPLE_BITS + 1 + COEF_BITS;
   localparam int SH_BITS      = ACC_BITS - COEF_FRAC_BITS;

   // Largest magnitudes of the signed result on each side.
   localparam int OUT_MAG_POS = (2 ** (OUT_BITS - 1)) - 1;
   localparam int OUT_MAG_NEG = 2 ** (OUT_BITS - 1);

   typedef logic signed [COEF_BITS-1:0] coef_type;

   // Symmetric Kaiser-Bessel high-pass design, Q1.19.
   localparam coef_type COEF_ROM [ROM_DEPTH] = '{
      -20'sd6,      20'sd40,      20'sd206,     20'sd431,     20'sd428,
      -20'sd225,    -20'sd1685,   -20'sd3331,   -20'sd3642,   -20'sd892,
      20'sd5372,    20'sd12902,   20'sd16569,   20'sd10207,   -20'sd10001,
      -20'sd42366,  -20'sd78888,  -20'sd107853, 20'sd405402,  -20'sd107853,
      -20'sd78888,  -20'sd42366,  -20'sd10001,  20'sd10207,   20'sd16569,
      20'sd12902,   20'sd5372,    -20'sd892,    -20'sd3642,   -20'sd3331,
      -20'sd1685,   -20'sd225,    20'sd428,     20'sd431,     20'sd206,
      20'sd40,      -20'sd6
   };

   typedef enum logic [1:0] {
      FHP_IDLE,
      FHP_MAC,
      FHP_DRAIN,
      FHP_FINISH
   } fhp_state_type;

   // Coefficient of a tap; taps past the ROM weigh zero.
   function automatic coef_type coef_at(input logic [TAP_BITS-1:0] k);
      coef_type c;
      c = '0;
      if (int'(k) < ROM_DEPTH) begin
         c = COEF_ROM[ROM_IDX_BITS'(k)];
      end
      return c;
   endfunction

endpackage

FILE: rtl/fir_highpass_37tap_unit.sv
// Top level of the 37-tap direct-form FIR high-pass unit.
// Depends on fhp_pkg and fir_highpass_37tap_unit_defines.svh.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_adc_sample[11:0] unsigned
//   rsp       out        rsp_valid/rsp_ready  rsp_filtered_value[13:0] signed,
//                                             rsp_raw_sample[11:0] unsigned
//
// Flow: a request is taken only while idle, so the unit finishes one request
//   before it takes the next. The single shared multiplier walks all 37
//   taps, one per cycle; a drain step then empties the product register and
//   a finish step rounds, saturates and writes the delay-line memory.
// Reset: synchronous, active high; clears control, the write pointer and the
//   fill count, so unwritten delay-line entries read as zero history.
// Stalls: the response sits in its own register; a new request may be taken
//   while it waits, and the finish step holds until that register is free.
`include "fir_highpass_37tap_unit_defines.svh"

module fir_highpass_37tap_unit
   import fhp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_BITS-1:0]     req_adc_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_BITS-1:0] rsp_filtered_value,
   output logic [SAMPLE_BITS-1:0]     rsp_raw_sample
);

   // Control state
   fhp_state_type          state_ff, state_in;
   logic [TAP_BITS-1:0]    tap_ff, tap_in;
   logic [TAP_BITS-1:0]    fill_ff, fill_in;
   logic [PTR_BITS-1:0]    ptr_ff, ptr_in;
   logic [PTR_BITS-1:0]    rd_addr_ff, rd_addr_in;
   logic                   prod_valid_ff, prod_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Datapath
   logic [SAMPLE_BITS-1:0]     x_ff, x_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic [OUT_BITS-1:0]        rsp_filt_ff, rsp_filt_in;
   logic [SAMPLE_BITS-1:0]     rsp_raw_ff, rsp_raw_in;

   // Delay-line memory: newest sample at ptr_ff, older ones below it.
   logic [SAMPLE_BITS-1:0] mem_ff [DLY_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   wr_en;
   logic [PTR_BITS-1:0]    ptr_next;

   // Rounding and saturation of the finished sum
   logic [ACC_BITS-1:0]    mag;
   logic [SH_BITS-1:0]     mag_sh;
   logic [SH_BITS-1:0]     neg_sh;
   logic [OUT_BITS-1:0]    y;
   logic [SAMPLE_BITS-1:0] operand;

   assign req_ready          = (state_ff == FHP_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = $signed(rsp_filt_ff);
   assign rsp_raw_sample     = rsp_raw_ff;

   assign ptr_next = (ptr_ff == PTR_BITS'(DLY_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   // Tap zero is the new sample; older taps come from memory, masked to zero
   // until the line has been filled that far.
   always_comb begin
      if (tap_ff == '0) begin
         operand = x_ff;
      end else if (tap_ff <= fill_ff) begin
         operand = rd_data_ff;
      end else begin
         operand = '0;
      end
   end

   // Truncate toward zero: shift the magnitude, then restore the sign.
   always_comb begin
      mag    = acc_ff[ACC_BITS-1] ? (~acc_ff + 1'b1) : acc_ff;
      mag_sh = mag[ACC_BITS-1:COEF_FRAC_BITS];
      neg_sh = ~mag_sh + 1'b1;
      if (acc_ff[ACC_BITS-1]) begin
         if (mag_sh > SH_BITS'(OUT_MAG_NEG)) begin
            y = OUT_BITS'(OUT_MAG_NEG);
         end else begin
            y = neg_sh[OUT_BITS-1:0];
         end
      end else begin
         if (mag_sh > SH_BITS'(OUT_MAG_POS)) begin
            y = OUT_BITS'(OUT_MAG_POS);
         end else begin
            y = mag_sh[OUT_BITS-1:0];
         end
      end
   end

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      rd_addr_in    = rd_addr_ff;
      x_in          = x_ff;
      prod_in       = prod_ff;
      prod_valid_in = 1'b0;
      acc_in        = prod_valid_ff ? (acc_ff + ACC_BITS'(prod_ff)) : acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_filt_in   = rsp_filt_ff;
      rsp_raw_in    = rsp_raw_ff;
      wr_en         = 1'b0;

      unique case (state_ff)
         FHP_IDLE: begin
            if (req_valid) begin
               x_in       = req_adc_sample;
               tap_in     = '0;
               rd_addr_in = ptr_ff;
               acc_in     = '0;
               state_in   = FHP_MAC;
            end
         end
         FHP_MAC: begin
            prod_in       = $signed({1'b0, operand}) * coef_at(tap_ff);
            prod_valid_in = 1'b1;
            // Walk back toward older samples, wrapping at the bottom.
            rd_addr_in    = (rd_addr_ff == '0) ? PTR_BITS'(DLY_DEPTH - 1)
                                               : rd_addr_ff - 1'b1;
            tap_in        = tap_ff + 1'b1;
            if (tap_ff == TAP_BITS'(TAPS - 1)) begin
               state_in = FHP_DRAIN;
            end
         end
         FHP_DRAIN: begin
            state_in = FHP_FINISH;
         end
         FHP_FINISH: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_filt_in  = y;
               rsp_raw_in   = x_ff;
               wr_en        = 1'b1;
               ptr_in       = ptr_next;
               if (fill_ff != TAP_BITS'(DLY_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in     = FHP_IDLE;
            end
         end
         default: begin
            state_in = FHP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FHP_IDLE;
         fill_ff       <= '0;
         ptr_ff        <= '0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         ptr_ff        <= ptr_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff      <= tap_in;
      rd_addr_ff  <= rd_addr_in;
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_raw_ff  <= rsp_raw_in;
   end

   // Delay-line memory: one write port, one registered read port. Reads of
   // an item end before its write, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[ptr_next] <= x_ff;
      end
      rd_data_ff <= mem_ff[rd_addr_ff];
   end

   `FHP_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= TAP_BITS'(DLY_DEPTH),
      "delay-line fill count past its depth")
   `FHP_ASSERT_NEXT(a_start_clean, clock, reset, req_valid && req_ready,
      state_ff == FHP_MAC && tap_ff == '0 && acc_ff == '0,
      "accepted request did not start a clean accumulation")
   `FHP_ASSERT_NOW(a_drain_has_product, clock, reset, state_ff == FHP_DRAIN, prod_valid_ff,
      "last product missing while draining")
   `FHP_ASSERT_NOW(a_finish_settled, clock, reset, state_ff == FHP_FINISH, !prod_valid_ff,
      "product still pending at finish")

endmodule

FILE: tb/sv/tb_fir_highpass_37tap_unit.sv
// Self-checking bench for the 37-tap FIR high-pass unit: streams samples through
// it, tracks the delay line and expected outputs in a small scoreboard class.
// Depends on fhp_pkg and the fir_highpass_37tap_unit RTL.

typedef struct packed {
   logic signed [fhp_pkg::OUT_BITS-1:0] filtered;
   logic [fhp_pkg::SAMPLE_BITS-1:0]     raw;
} highpass_out_type;

class highpass_tracker;
   int                                weight[37];
   logic [fhp_pkg::SAMPLE_BITS-1:0]   history[36];
   highpass_out_type                  pending[$];
   int                                mismatches;
   int                                responses_seen;

   function new();
      // Q1.19 weights of the symmetric high-pass design, oldest tap last
      weight = '{-6, 40, 206, 431, 428, -225, -1685, -3331, -3642, -892,
                 5372, 12902, 16569, 10207, -10001, -42366, -78888, -107853,
                 405402, -107853, -78888, -42366, -10001, 10207, 16569, 12902,
                 5372, -892, -3642, -3331, -1685, -225, 428, 431, 206, 40, -6};
      foreach (history[i]) history[i] = '0;
      mismatches     = 0;
      responses_seen = 0;
   endfunction

   // Run one sample through the tap history and return the expected output.
   function highpass_out_type filter_sample(input logic [fhp_pkg::SAMPLE_BITS-1:0] x);
      longint           acc;
      longint           mag;
      longint           y;
      bit               neg;
      highpass_out_type r;
      acc = longint'(x) * longint'(weight[0]);
      for (int k = 1; k < 37; k++) begin
         acc += longint'(history[k-1]) * longint'(weight[k]);
      end
      // shift the magnitude so negative sums truncate toward zero
      neg = (acc < 0);
      mag = neg ? -acc : acc;
      mag = mag >> 19;
      if (neg) begin
         y = (mag > 8192) ? -8192 : -mag;
      end else begin
         y = (mag > 8191) ? 8191 : mag;
      end
      for (int k = 35; k > 0; k--) begin
         history[k] = history[k-1];
      end
      history[0] = x;
      r.filtered = y[fhp_pkg::OUT_BITS-1:0];
      r.raw      = x;
      return r;
   endfunction

   function void note_request(input logic [fhp_pkg::SAMPLE_BITS-1:0] x);
      pending.push_back(filter_sample(x));
   endfunction

   function void check_response(input logic signed [fhp_pkg::OUT_BITS-1:0] filtered,
                                 input logic [fhp_pkg::SAMPLE_BITS-1:0] raw);
      highpass_out_type want;
      responses_seen++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d with nothing pending: filtered %0d raw %0d",
                     responses_seen, filtered, raw);
         return;
      end
      want = pending.pop_front();
      if (filtered !== want.filtered) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d filtered: expected %0d got %0d",
                     responses_seen, want.filtered, filtered);
      end
      if (raw !== want.raw) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d raw: expected %0d got %0d",
                     responses_seen, want.raw, raw);
      end
   endfunction
endclass

module tb_fir_highpass_37tap_unit;
   import fhp_pkg::*;

   localparam int RANDOM_REQUESTS = 600;
   localparam int HOLD_CYCLES     = 320;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [SAMPLE_BITS-1:0]     req_adc_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_filtered_value;
   logic [SAMPLE_BITS-1:0]     rsp_raw_sample;

   highpass_tracker tracker;
   int              burst_left = 0;

   fir_highpass_37tap_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_adc_sample     (req_adc_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_raw_sample     (rsp_raw_sample)
   );

   always #2 clock = ~clock;

   // Watch both handshakes at every edge. Check the response before noting a
   // new request so a stray response can never consume a fresh expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_filtered_value, rsp_raw_sample);
         if (req_valid && req_ready)
            tracker.note_request(req_adc_sample);
      end
   end

   // Offer one request and hold it until the unit takes it. Returns in the
   // time step of the accepting edge, with valid still high.
   task automatic send_request(input logic [SAMPLE_BITS-1:0] sample);
      req_valid      <= 1'b1;
      req_adc_sample <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Count down the current burst; when it runs out, drop valid for a random
   // gap. Long gaps (up to past one full pass of the unit) land idles on every
   // phase of the multiply-accumulate walk.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 55) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Receiver: ready follows a pattern chosen per stretch. Once enough
   // responses have gone by, hold off for a long stretch so the response
   // register fills, the next request lands behind it and the input stalls.
   initial begin : receiver
      int  mode;
      int  span;
      int  tick;
      bit  held_off;
      held_off = 0;
      tick     = 0;
      @(negedge reset);
      forever begin
         if (!held_off && tracker.responses_seen >= 150) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held_off = 1;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            tick++;
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= ($urandom_range(0, 7) == 0);
               end
               2: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_ready <= (tick % 7) < 3;
               end
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [SAMPLE_BITS-1:0] sample;
      logic [SAMPLE_BITS-1:0] prev;
      int                     pick;
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: impulse, then a full-scale step, then the Nyquist-rate
      // square wave that drives the sum hardest negative and positive, then
      // bit patterns and the edges of the sample range.
      send_request(12'd0);
      send_request(12'd0);
      send_request(12'd4095);
      send_request(12'd0);
      send_request(12'd0);
      send_request(12'd0);
      repeat (4) send_request(12'd4095);
      repeat (5) begin
         send_request(12'd0);
         send_request(12'd4095);
      end
      send_request(12'd2048);
      send_request(12'd1);
      send_request(12'd4094);
      send_request(12'hAAA);
      send_request(12'h555);

      // Random: mostly uniform samples, with runs of extremes and of
      // alternating values to push the output toward both limits.
      prev = 12'h555;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pace_sender();
         pick = $urandom_range(0, 99);
         if (pick < 50)
            sample = 12'($urandom_range(0, 4095));
         else if (pick < 70)
            sample = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
         else if (pick < 85)
            sample = ~prev;
         else
            sample = 12'd2048 + 12'($urandom_range(0, 63)) - 12'd32;
         send_request(sample);
         prev = sample;
      end
      req_valid <= 1'b0;

      // Drain: wait for every expected response, then idle a while so any
      // extra response would still be caught.
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of ~625 requests.
   initial begin : watchdog
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
